// ----- design/bfns_pkg.sv -----
// shared types for the best fit normal search controller and datapath
package bfns_pkg;

    typedef struct packed {
        logic load;
        logic eval;
        logic dot;
        logic sq;
        logic pp;
        logic cmp;
    } t_cmd;

    typedef struct packed {
        logic last_step;
    } t_stat;

endpackage

// ----- design/bfns_ctrl.sv -----
// sequencer that walks each ray step through the datapath phases
module bfns_ctrl
    import bfns_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy,
    output logic  o_valid
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DOT  = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_PP   = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = S_EVAL;
            S_EVAL: n_state = S_DOT;
            S_DOT:  n_state = S_SQ;
            S_SQ:   n_state = S_PP;
            S_PP:   n_state = S_CMP;
            S_CMP:  n_state = i_stat.last_step ? S_DONE : S_EVAL;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.load = (r_state == S_IDLE) && start;
    assign o_cmd.eval = (r_state == S_EVAL);
    assign o_cmd.dot  = (r_state == S_DOT);
    assign o_cmd.sq   = (r_state == S_SQ);
    assign o_cmd.pp   = (r_state == S_PP);
    assign o_cmd.cmp  = (r_state == S_CMP);
    assign busy       = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_DONE);

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) && i_stat.last_step |=> (r_state == S_DONE))
        else $error("last step did not finish the search");

endmodule

// ----- design/bfns_dpath.sv -----
// candidate evaluation, exact cross-multiplied compare and best triple store
module bfns_dpath
    import bfns_pkg::*;
#(
    parameter int STEP_COUNT = 256,
    parameter int LEVELS     = 256
) (
    input  logic               i_clk,
    input  t_cmd               i_cmd,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    output t_stat              o_stat,
    output logic [7:0]         o_fit_x,
    output logic [7:0]         o_fit_y,
    output logic [7:0]         o_fit_z
);

    localparam int KW   = $clog2(STEP_COUNT);
    localparam int LW   = $clog2(LEVELS);
    localparam int MAXV = LEVELS - 1;
    localparam int BASE = MAXV * 16384;
    localparam int NUMW = ((LW + 14 > 16 + KW) ? LW + 14 : 16 + KW) + 2;
    localparam int QW   = NUMW - 15;
    localparam int MW   = 17 + KW;
    localparam int CW   = LW + 1;
    localparam int CTW  = CW + 16;
    localparam int TW   = CW + 18;
    localparam int RW   = 2 * CW;
    localparam int AW   = LW + 17;
    localparam int SW   = 2 * AW;
    localparam int PPW  = AW + RW;
    localparam int PW   = SW + RW;

    logic signed [15:0]   r_nv [3];
    logic [KW-1:0]        r_k;
    logic [LW-1:0]        r_q [3];
    logic signed [CW-1:0] r_c [3];
    logic signed [TW-1:0] r_t;
    logic [RW-1:0]        r_r;
    logic                 r_tneg;
    logic [SW-1:0]        r_tsq;
    logic [PPW-1:0]       r_pa_hi, r_pa_lo, r_pb_hi, r_pb_lo;
    logic [LW-1:0]        r_best_q [3];
    logic                 r_best_neg;
    logic [SW-1:0]        r_best_tsq;
    logic [RW-1:0]        r_best_r;

    logic signed [MW-1:0]   w_prod [3];
    logic signed [NUMW-1:0] w_num [3];
    logic [LW-1:0]          w_q [3];
    logic signed [CW:0]     w_c2 [3];
    logic signed [CTW-1:0]  w_ct [3];
    logic signed [RW-1:0]   w_cc [3];
    logic signed [TW-1:0]   w_t;
    logic signed [RW-1:0]   w_rs;
    logic signed [TW-1:0]   w_tabs;
    logic [AW-1:0]          w_tmag;
    logic [PW-1:0]          w_lhs, w_rhs;
    logic                   w_win;

    // ray step position per component, truncated and clamped to 0..LEVELS-1
    for (genvar j = 0; j < 3; j++) begin : g_comp
        assign w_prod[j] = r_nv[j] * $signed({1'b0, r_k});
        assign w_num[j]  = w_prod[j] + NUMW'(BASE);
        always_comb begin
            priority if (w_num[j][NUMW-1]) begin
                w_q[j] = '0;
            end else if (w_num[j][NUMW-1:15] > QW'(MAXV)) begin
                w_q[j] = LW'(MAXV);
            end else begin
                w_q[j] = w_num[j][LW+14:15];
            end
        end
        assign w_c2[j] = $signed({1'b0, w_q[j], 1'b0}) - $signed((CW+1)'(MAXV));
        assign w_ct[j] = r_c[j] * r_nv[j];
        assign w_cc[j] = r_c[j] * r_c[j];
    end

    assign w_t    = w_ct[0] + w_ct[1] + w_ct[2];
    assign w_rs   = w_cc[0] + w_cc[1] + w_cc[2];
    assign w_tabs = r_t[TW-1] ? -r_t : r_t;
    assign w_tmag = w_tabs[AW-1:0];

    // t_cur^2 * r_best against t_best^2 * r_cur, from split partial products
    assign w_lhs = {r_pa_hi, {AW{1'b0}}} + PW'(r_pa_lo);
    assign w_rhs = {r_pb_hi, {AW{1'b0}}} + PW'(r_pb_lo);

    always_comb begin
        priority if (r_k == '0) begin
            w_win = 1'b1;
        end else if (r_r == '0) begin
            w_win = 1'b0;
        end else if (r_best_r == '0) begin
            w_win = 1'b1;
        end else if (r_tneg != r_best_neg) begin
            w_win = !r_tneg;
        end else if (!r_tneg) begin
            w_win = (w_lhs > w_rhs);
        end else begin
            w_win = (w_lhs < w_rhs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_nv[0] <= i_normal_x;
            r_nv[1] <= i_normal_y;
            r_nv[2] <= i_normal_z;
            r_k     <= '0;
        end
        if (i_cmd.eval) begin
            for (int j = 0; j < 3; j++) begin
                r_q[j] <= w_q[j];
                r_c[j] <= w_c2[j][CW-1:0];
            end
        end
        if (i_cmd.dot) begin
            r_t <= w_t;
            r_r <= $unsigned(w_rs);
        end
        if (i_cmd.sq) begin
            r_tsq  <= w_tmag * w_tmag;
            r_tneg <= r_t[TW-1];
        end
        if (i_cmd.pp) begin
            r_pa_hi <= r_tsq[SW-1:AW] * r_best_r;
            r_pa_lo <= r_tsq[AW-1:0] * r_best_r;
            r_pb_hi <= r_best_tsq[SW-1:AW] * r_r;
            r_pb_lo <= r_best_tsq[AW-1:0] * r_r;
        end
        if (i_cmd.cmp) begin
            r_k <= r_k + 1'b1;
            if (w_win) begin
                r_best_q   <= r_q;
                r_best_neg <= r_tneg;
                r_best_tsq <= r_tsq;
                r_best_r   <= r_r;
            end
        end
    end

    assign o_stat.last_step = (r_k == KW'(STEP_COUNT - 1));
    assign o_fit_x = 8'(r_best_q[0]);
    assign o_fit_y = 8'(r_best_q[1]);
    assign o_fit_z = 8'(r_best_q[2]);

endmodule

// ----- design/best_fit_normal_search_core.sv -----
// top level of the best fit normal search core
// usage:
// - a request carries a direction (i_normal_x/y/z, signed q1.14) and is
//   taken at a rising edge where start is high and busy is low
// - the core walks STEP_COUNT half steps along the ray from the cube center,
//   forms the clamped byte triple at each step and keeps the one whose
//   normalized direction lies closest to the request, first one on a tie
// - each step runs five phases in the shared evaluator: position and
//   clamp, dot product and length, squaring, partial products, compare
// - the strobe o_valid rises in the done state that follows the compare of
//   the last step and lasts one cycle with o_fit_x/y/z, so the result is
//   taken at the edge that leaves the done state; busy drops at that same
//   edge, so a new request is taken only once the previous result is out
// - the receiver cannot stall: the result is presented once and gone
// - reset (synchronous, active low) returns the sequencer to idle; any
//   search in flight is dropped and no result is produced for it
// - the compare is exact: squared dot products are cross multiplied with
//   squared lengths, so no rounding enters the choice
module best_fit_normal_search_core
    import bfns_pkg::*;
#(
    parameter int STEP_COUNT = 256,
    parameter int LEVELS     = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    output logic               o_valid,
    output logic [7:0]         o_fit_x,
    output logic [7:0]         o_fit_y,
    output logic [7:0]         o_fit_z
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: one phase per cycle for every ray step
    bfns_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    // evaluator and best candidate store
    bfns_dpath #(
        .STEP_COUNT (STEP_COUNT),
        .LEVELS     (LEVELS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_normal_x (i_normal_x),
        .i_normal_y (i_normal_y),
        .i_normal_z (i_normal_z),
        .o_stat     (w_stat),
        .o_fit_x    (o_fit_x),
        .o_fit_y    (o_fit_y),
        .o_fit_z    (o_fit_z)
    );

    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("request not taken up");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result outside a search");

endmodule
